### hdl/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, constants and small table functions for the calendar word
// encoder.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int unsigned YearW      = 12;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned DayW       = 5;
  localparam int unsigned FieldW     = 6;
  localparam int unsigned YearOffW   = 8;
  localparam int unsigned TimeWordW  = 21;
  localparam int unsigned DateWordW  = 32;

  localparam logic [YearW-1:0]    EpochYear   = 12'd1970;
  localparam logic [YearW-1:0]    LastYear    = 12'd2225;
  localparam logic [YearOffW-1:0] Year2100Off = 8'd130;
  localparam logic [YearOffW-1:0] Year2200Off = 8'd230;
  localparam logic [MonthW-1:0]   MonthFeb    = 4'd1;
  localparam logic [MonthW-1:0]   MonthCount  = 4'd12;
  localparam logic [FieldW-1:0]   HoursPerDay = 6'd24;
  localparam logic [FieldW-1:0]   SixtyLimit  = 6'd60;

  localparam logic KindSetTime  = 1'b0;
  localparam logic KindSetAlarm = 1'b1;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic [FieldW-1:0] alarm_hour;
    logic [FieldW-1:0] alarm_minute;
    logic [FieldW-1:0] alarm_second;
  } rce_item_t;

  typedef struct packed {
    logic [TimeWordW-1:0] time_word;
    logic [DateWordW-1:0] date_word;
    logic                 status;
  } rce_result_t;

  // Days in a month of a common year; codes past December never pass
  // validation.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon);
    logic [DayW-1:0] len;
    unique case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Day of year at which each month starts, reduced modulo 7.
  function automatic logic [2:0] month_start_mod7(input logic [MonthW-1:0] mon);
    logic [2:0] r;
    unique case (mon)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd6;
      4'd4:    r = 3'd1;
      4'd5:    r = 3'd4;
      4'd6:    r = 3'd6;
      4'd7:    r = 3'd2;
      4'd8:    r = 3'd5;
      4'd9:    r = 3'd0;
      4'd10:   r = 3'd3;
      4'd11:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Remainder modulo 7 of a 10-bit value. Since 8 is 1 modulo 7, the octal
  // digits are summed twice and one final subtract brings it into range.
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {1'b0, x[9:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
    s2 = {2'b00, s1[4:3]} + {1'b0, s1[2:0]};
    r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
    return r[2:0];
  endfunction

endpackage

### hdl/rce_weekday.sv
// ----------------------------------------------------------------------------
// rce_weekday
// Weekday of a date between 1970 and 2225, 0 for Sunday through 6 for
// Saturday.
// ----------------------------------------------------------------------------
module rce_weekday (
  input  logic [rce_pkg::YearOffW-1:0] year_off_i,
  input  logic [rce_pkg::MonthW-1:0]   month_i,
  input  logic [rce_pkg::DayW-1:0]     day_i,
  input  logic                         leap_i,
  output logic [2:0]                   weekday_o
);
  import rce_pkg::*;

  logic [8:0] year_next;
  logic [6:0] leap4_cnt;
  logic [1:0] century_cnt;
  logic [6:0] leap_cnt;
  logic       feb_adj;
  logic [9:0] day_sum;

  // Leap days strictly before this year, counted from 1970. Of the century
  // years in range only 2100 and 2200 are skipped; 2000 is a leap year.
  assign year_next   = {1'b0, year_off_i} + 9'd1;
  assign leap4_cnt   = year_next[8:2];
  assign century_cnt = {1'b0, (year_off_i > Year2100Off)} +
                       {1'b0, (year_off_i > Year2200Off)};
  assign leap_cnt    = leap4_cnt - {5'd0, century_cnt};
  assign feb_adj     = leap_i && (month_i > MonthFeb);

  // 1 January 1970 was a Thursday, and 365 is 1 modulo 7. The constant 3
  // folds the Thursday offset with the one-based day.
  assign day_sum = 10'd3 + {2'b00, year_off_i} + {3'd0, leap_cnt} +
                   {7'd0, month_start_mod7(month_i)} + {9'd0, feb_adj} +
                   {5'd0, day_i};

  assign weekday_o = mod7(day_sum);

endmodule

### hdl/rce_encode.sv
// ----------------------------------------------------------------------------
// rce_encode
// Alarm merge, field validation and packing of the time and date words.
// ----------------------------------------------------------------------------
module rce_encode (
  input  rce_pkg::rce_item_t   item_i,
  output rce_pkg::rce_result_t result_o
);
  import rce_pkg::*;

  logic [FieldW-1:0]   hour;
  logic [FieldW-1:0]   minute;
  logic [FieldW-1:0]   second;
  logic [YearW-1:0]    year_diff;
  logic [YearOffW-1:0] year_off;
  logic                leap;
  logic [DayW:0]       day_lim;
  logic                range_ok;
  logic                valid;
  logic [2:0]          weekday;
  logic [7:0]          month_byte;

  always_comb begin
    hour   = item_i.hour;
    minute = item_i.minute;
    second = item_i.second;
    if (item_i.kind == KindSetAlarm) begin
      if (item_i.alarm_hour < HoursPerDay) begin
        hour = item_i.alarm_hour;
      end
      if (item_i.alarm_minute < SixtyLimit) begin
        minute = item_i.alarm_minute;
      end
      if (item_i.alarm_second < SixtyLimit) begin
        second = item_i.alarm_second;
      end
    end
  end

  assign year_diff = item_i.year - EpochYear;
  assign year_off  = year_diff[YearOffW-1:0];

  // Within the accepted years a year is leap when it is two past a multiple
  // of four from 1970, except 2100 and 2200.
  assign leap = (year_off[1:0] == 2'd2) && (year_off != Year2100Off) &&
                (year_off != Year2200Off);

  assign day_lim = {1'b0, month_len(item_i.month)} +
                   {5'd0, (item_i.month == MonthFeb) && leap};

  assign range_ok = (item_i.year >= EpochYear) && (item_i.year <= LastYear) &&
                    (item_i.month < MonthCount) && (item_i.day != '0) &&
                    (hour < HoursPerDay) && (minute < SixtyLimit) &&
                    (second < SixtyLimit);
  assign valid    = range_ok && ({1'b0, item_i.day} <= day_lim);

  rce_weekday u_weekday (
    .year_off_i (year_off),
    .month_i    (item_i.month),
    .day_i      (item_i.day),
    .leap_i     (leap),
    .weekday_o  (weekday)
  );

  assign month_byte = {4'd0, item_i.month} + 8'd1;

  always_comb begin
    if (valid) begin
      result_o.time_word = {hour[4:0], 2'b00, minute, 2'b00, second};
      result_o.date_word = {year_off, month_byte, 3'b000, item_i.day,
                            5'd0, weekday + 3'd1};
      result_o.status    = StatusOk;
    end else begin
      result_o.time_word = '0;
      result_o.date_word = '0;
      result_o.status    = StatusInvalid;
    end
  end

endmodule

### hdl/rtc_calendar_word_encoder.sv
// ----------------------------------------------------------------------------
// rtc_calendar_word_encoder
// Packs a calendar time, or an alarm merged into the current time, into the
// clock's time and date register words.
// ----------------------------------------------------------------------------
// Each word entering the block passes through two registers, the input
// register and then the result register, with the alarm merge,
// validation, weekday and packing done by short logic between the two. The
// block accepts a new word every cycle; ready drops only when both
// registers hold a word and the output side is stalled. The weekday comes
// from a leap count and a fold modulo 7, so there is no loop or memory.
// ----------------------------------------------------------------------------
module rtc_calendar_word_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [rce_pkg::YearW-1:0]      year_i,
  input  logic [rce_pkg::MonthW-1:0]     month_i,
  input  logic [rce_pkg::DayW-1:0]       day_i,
  input  logic [rce_pkg::FieldW-1:0]     hour_i,
  input  logic [rce_pkg::FieldW-1:0]     minute_i,
  input  logic [rce_pkg::FieldW-1:0]     second_i,
  input  logic [rce_pkg::FieldW-1:0]     alarm_hour_i,
  input  logic [rce_pkg::FieldW-1:0]     alarm_minute_i,
  input  logic [rce_pkg::FieldW-1:0]     alarm_second_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rce_pkg::TimeWordW-1:0]  time_word_o,
  output logic [rce_pkg::DateWordW-1:0]  date_word_o,
  output logic                           status_o
);
  import rce_pkg::*;

  rce_item_t   item_d, item_q;
  logic        item_valid_q;
  rce_result_t result_d, result_q;
  logic        result_valid_q;
  logic        result_ready;

  assign result_ready = !result_valid_q || out_ready_i;
  assign in_ready_o   = !item_valid_q || result_ready;

  assign item_d = '{kind:         kind_i,
                    year:         year_i,
                    month:        month_i,
                    day:          day_i,
                    hour:         hour_i,
                    minute:       minute_i,
                    second:       second_i,
                    alarm_hour:   alarm_hour_i,
                    alarm_minute: alarm_minute_i,
                    alarm_second: alarm_second_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (result_ready) begin
        result_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
    if (item_valid_q && result_ready) begin
      result_q <= result_d;
    end
  end

  rce_encode u_encode (
    .item_i   (item_q),
    .result_o (result_d)
  );

  assign out_valid_o = result_valid_q;
  assign time_word_o = result_q.time_word;
  assign date_word_o = result_q.date_word;
  assign status_o    = result_q.status;

  // An invalid result carries all-zero words.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusInvalid) |->
      (time_word_o == '0) && (date_word_o == '0))
    else $error("invalid result with nonzero words");

  // A good date has month byte 1..12 and weekday byte 1..7.
  a_date_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusOk) |->
      (date_word_o[23:16] >= 8'd1) && (date_word_o[23:16] <= 8'd12) &&
      (date_word_o[7:0] >= 8'd1) && (date_word_o[7:0] <= 8'd7))
    else $error("month or weekday byte out of range");

  // A word held in the input register while the output stalls stays there.
  a_item_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !result_ready |=> item_valid_q && $stable(item_q))
    else $error("input register lost a stalled word");

  // An accepted word always lands in the input register.
  a_item_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> item_valid_q)
    else $error("accepted word not captured");

  // A word leaving the input register always reaches the output.
  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && result_ready |=> out_valid_o)
    else $error("word dropped between stages");

endmodule
